>>> hw/rtl/esa_pkg.sv
`default_nettype none
package esa_pkg;

  localparam int MAX_RING_LOG2_DEF = 20;

  localparam int MODE_W  = 2;
  localparam int LEN_W   = 21;
  localparam int KIND_W  = 3;
  localparam int OFF_W   = 20;
  localparam int CNT_W   = 21;
  localparam int SEQ_W   = 64;
  localparam int PTR_W   = 64;

  localparam int LG_W       = 5;
  localparam int LIMIT_W    = 63;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 63;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 112;

  localparam int OUTQ_DEPTH = 4;

  localparam logic [LG_W-1:0]    RING_LOG2_RESET = 5'd12;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET     = {LIMIT_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RING_LOG2 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME  = 1'd1;

  // request modes
  localparam logic [MODE_W-1:0] MODE_SEND    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CONSUME = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CWRAP   = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_PLACED    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PAD       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TOO_LARGE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LIFETIME  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RETRY     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CONSUMED  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_CWRAPPED  = 3'd6;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OFF_W-1:0]  offset;
    logic [CNT_W-1:0]  count;
    logic [SEQ_W-1:0]  seq;
    logic              last;
  } result_t;

  // up to two results leave the core per item
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic result_t make_result(logic [KIND_W-1:0] kind, logic [OFF_W-1:0] offset,
                                          logic [CNT_W-1:0] count, logic [SEQ_W-1:0] seq,
                                          logic last);
    result_t r;
    r.kind   = kind;
    r.offset = offset;
    r.count  = count;
    r.seq    = seq;
    r.last   = last;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/esa_core.sv
`default_nettype none
module esa_core #(
  parameter int MAX_RING_LOG2 = esa_pkg::MAX_RING_LOG2_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [esa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [esa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           take,
  input  wire logic [esa_pkg::MODE_W-1:0]     in_mode,
  input  wire logic [esa_pkg::LEN_W-1:0]      in_len,
  output esa_pkg::push_t                      push
);
  import esa_pkg::*;

  localparam int MW = MAX_RING_LOG2;
  localparam int SW = MAX_RING_LOG2 + 1;
  localparam int CW = (SW > LEN_W) ? SW : LEN_W;

  logic [LG_W-1:0]    ring_log2;
  logic [LIMIT_W-1:0] limit;
  logic [PTR_W-1:0]   prod, prod_next;
  logic [PTR_W-1:0]   cons, cons_next;
  logic [SEQ_W-1:0]   seq, seq_next;

  logic [LG_W-1:0]  lg_eff;
  logic [SW-1:0]    ring_bytes;
  logic [MW-1:0]    mask;
  logic [MW-1:0]    roff, eoff, cidx;
  logic [SW-1:0]    pad_cnt, cwrap_cnt;
  logic [PTR_W:0]   end1, pnext, end2;
  logic [PTR_W-1:0] pbase;
  logic             too_large, ovf1, retry1, pad1, ovf2, retry2;
  logic [1:0]       num;
  result_t          r0, r1;

  always_comb begin
    if (ring_log2 < LG_W'(4)) begin
      lg_eff = LG_W'(4);
    end else if (ring_log2 > LG_W'(MAX_RING_LOG2)) begin
      lg_eff = LG_W'(MAX_RING_LOG2);
    end else begin
      lg_eff = ring_log2;
    end
  end

  assign ring_bytes = SW'(1) << lg_eff;
  assign mask       = MW'(ring_bytes - SW'(1));

  // first judgment at the current producer
  assign too_large = (in_len == '0) || (CW'(in_len) >= CW'(ring_bytes));
  assign end1      = {1'b0, prod} + (PTR_W + 1)'(in_len);
  assign ovf1      = end1[PTR_W] || (end1[PTR_W-1:0] > {1'b0, limit});
  assign retry1    = (end1[PTR_W-1:0] - cons) > PTR_W'(ring_bytes);
  assign roff      = prod[MW-1:0] & mask;
  assign eoff      = end1[MW-1:0] & mask;
  assign pad1      = eoff <= roff;
  assign pad_cnt   = ring_bytes - SW'(roff);

  // second judgment after the jump to the next ring start
  assign pbase  = prod & ~PTR_W'(mask);
  assign pnext  = {1'b0, pbase} + (PTR_W + 1)'(ring_bytes);
  assign end2   = {1'b0, pnext[PTR_W-1:0]} + (PTR_W + 1)'(in_len);
  assign ovf2   = end2[PTR_W] || (end2[PTR_W-1:0] > {1'b0, limit});
  assign retry2 = (end2[PTR_W-1:0] - cons) > PTR_W'(ring_bytes);

  assign cidx      = cons[MW-1:0] & mask;
  assign cwrap_cnt = ring_bytes - SW'(cidx);

  always_comb begin
    num       = 2'd0;
    r0        = make_result(KIND_PLACED, '0, '0, '0, 1'b1);
    r1        = make_result(KIND_PLACED, '0, '0, '0, 1'b1);
    prod_next = prod;
    cons_next = cons;
    seq_next  = seq;
    case (in_mode)
      MODE_SEND: begin
        num = 2'd1;
        if (too_large) begin
          r0 = make_result(KIND_TOO_LARGE, '0, CNT_W'(in_len), '0, 1'b1);
        end else if (ovf1) begin
          r0 = make_result(KIND_LIFETIME, '0, CNT_W'(in_len), '0, 1'b1);
        end else if (retry1) begin
          r0 = make_result(KIND_RETRY, '0, CNT_W'(in_len), '0, 1'b1);
        end else if (pad1) begin
          num       = 2'd2;
          r0        = make_result(KIND_PAD, OFF_W'(roff), CNT_W'(pad_cnt), '0, 1'b0);
          prod_next = pnext[PTR_W-1:0];
          if (ovf2) begin
            r1 = make_result(KIND_LIFETIME, '0, CNT_W'(in_len), '0, 1'b1);
          end else if (retry2) begin
            r1 = make_result(KIND_RETRY, '0, CNT_W'(in_len), '0, 1'b1);
          end else begin
            r1        = make_result(KIND_PLACED, '0, CNT_W'(in_len), seq, 1'b1);
            prod_next = end2[PTR_W-1:0];
            seq_next  = seq + SEQ_W'(1);
          end
        end else begin
          r0        = make_result(KIND_PLACED, OFF_W'(roff), CNT_W'(in_len), seq, 1'b1);
          prod_next = end1[PTR_W-1:0];
          seq_next  = seq + SEQ_W'(1);
        end
      end
      MODE_CONSUME: begin
        num       = 2'd1;
        r0        = make_result(KIND_CONSUMED, OFF_W'(cidx), CNT_W'(in_len), '0, 1'b1);
        cons_next = cons + PTR_W'(in_len);
      end
      MODE_CWRAP: begin
        num       = 2'd1;
        r0        = make_result(KIND_CWRAPPED, OFF_W'(cidx), CNT_W'(cwrap_cnt), '0, 1'b1);
        cons_next = cons + PTR_W'(cwrap_cnt);
      end
      default: begin
        num = 2'd0;
      end
    endcase
  end

  assign push.num = take ? num : 2'd0;
  assign push.r0  = r0;
  assign push.r1  = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_log2 <= RING_LOG2_RESET;
      limit     <= LIMIT_RESET;
      prod      <= '0;
      cons      <= '0;
      seq       <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_RING_LOG2) begin
        ring_log2 <= cfg_data[LG_W-1:0];
      end
      if (cfg_we && cfg_index == CFG_LIFETIME) begin
        limit <= cfg_data[LIMIT_W-1:0];
      end
      if (take) begin
        prod <= prod_next;
        cons <= cons_next;
        seq  <= seq_next;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/esa_outq.sv
`default_nettype none
module esa_outq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire esa_pkg::push_t push,
  output logic                room,
  output logic                out_valid,
  input  wire logic           out_ready,
  output esa_pkg::result_t    out_result
);
  import esa_pkg::*;

  localparam int QP_W = $clog2(OUTQ_DEPTH);

  result_t         entries [OUTQ_DEPTH];
  logic [QP_W-1:0] rd_ptr;
  logic [QP_W-1:0] wr_ptr;
  logic [QP_W:0]   count;
  logic            pop;

  assign out_valid  = count != '0;
  assign out_result = entries[rd_ptr];
  assign pop        = out_valid && out_ready;
  // two free slots cover a send that pads and places
  assign room       = count <= (QP_W + 1)'(OUTQ_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.num == 2'd2) begin
      entries[wr_ptr + QP_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QP_W'(push.num);
      rd_ptr <= rd_ptr + QP_W'(pop);
      count  <= count + (QP_W + 1)'(push.num) - (QP_W + 1)'(pop);
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/eager_ring_space_allocator_top.sv
// Eager ring space allocator.
// Timing: an accepted item waits in the input register until the queue has room for it;
// then its results enter the queue and are offered in order, a padded send's pad first.
// Throughput: one item per cycle while the queue has room; the master side moves one result
// per cycle while m_axis_tready is high, so a run of padded sends can stall the input.
// Reset (rst, synchronous): pointers and sequence to zero, registers to defaults, queue empty.
`default_nettype none
module eager_ring_space_allocator_top #(
  parameter int MAX_RING_LOG2 = esa_pkg::MAX_RING_LOG2_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [esa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [esa_pkg::CFG_DATA_W-1:0]  cfg_data,
  // request stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [esa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [20:0] length
  input  wire logic [esa_pkg::MODE_W-1:0]      s_axis_tuser,  // [1:0] mode
  // result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [esa_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // [19:0] ring_offset,
                                                               // [40:20] byte_count,
                                                               // [104:41] sequence_number
  output logic [esa_pkg::KIND_W-1:0]           m_axis_tuser,  // [2:0] result_kind
  output logic                                 m_axis_tlast
);
  import esa_pkg::*;

  // input register
  logic              in_valid;
  logic [MODE_W-1:0] in_mode;
  logic [LEN_W-1:0]  in_len;
  logic              take;
  logic              room;
  push_t             push;
  result_t           out_result;

  // judge the held item once the queue has space for both possible results
  assign take          = in_valid && room;
  assign s_axis_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  // payload: load on every transfer, no reset needed
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode <= s_axis_tuser;
      in_len  <= s_axis_tdata[LEN_W-1:0];
    end
  end

  esa_core #(
    .MAX_RING_LOG2(MAX_RING_LOG2)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .take     (take),
    .in_mode  (in_mode),
    .in_len   (in_len),
    .push     (push)
  );

  esa_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_result(out_result)
  );

  // pack the result: offset lowest, then count, then sequence, zero fill on top
  assign m_axis_tdata = {(OUT_TDATA_W - OFF_W - CNT_W - SEQ_W)'(0),
                         out_result.seq, out_result.count, out_result.offset};
  assign m_axis_tuser = out_result.kind;
  assign m_axis_tlast = out_result.last;

endmodule
`default_nettype wire

>>> hw/rtl/esa_checker.sv
`default_nettype none
module esa_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [esa_pkg::KIND_W-1:0]      m_axis_tuser,
  input wire logic                            m_axis_tlast
);
  import esa_pkg::*;

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // padding is queued together with its follow-up result
  a_pad_follow: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_PAD |=> m_axis_tvalid)
    else $error("no result after padding");

  // only padding leaves an item unfinished
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != KIND_PAD)))
    else $error("last flag does not match result kind");

  // reset empties the queue and opens the input
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid && s_axis_tready)
    else $error("state after reset");

endmodule

bind eager_ring_space_allocator_top esa_checker u_esa_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
`default_nettype wire

>>> bench/eager_ring_space_allocator_top_test.sv
`timescale 1ns / 100ps
`default_nettype none
module eager_ring_space_allocator_top_test;
  import esa_pkg::*;

  // Hard stop for a hung run.
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 200;
  // the fourth mode code, which the block must drop without a result
  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OFF_W-1:0]  offset;
    logic [CNT_W-1:0]  count;
    logic [SEQ_W-1:0]  seq;
    logic              last;
  } alloc_result_t;

  // one row of the directed table: either a register write or a request
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] reg_sel;
    logic [LIMIT_W-1:0]   reg_val;
    logic [MODE_W-1:0]    mode;
    logic [LEN_W-1:0]     len;
    bit                   typed;
    alloc_result_t        want;
  } plan_step_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [MODE_W-1:0]      s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]      m_axis_tuser;
  logic                   m_axis_tlast;

  // Predictor state: ring registers and the three pointers.
  logic [LG_W-1:0]    ring_lg = RING_LOG2_RESET;
  logic [LIMIT_W-1:0] lifetime_cap = LIMIT_RESET;
  logic [PTR_W-1:0]   prod_ptr = '0;
  logic [PTR_W-1:0]   cons_ptr = '0;
  logic [SEQ_W-1:0]   seq_next = '0;

  alloc_result_t pending[$];   // results owed by the block, oldest first
  plan_step_t    plan[$];
  int            kind_seen[0:7];
  int            fail_count = 0;
  int            requests_sent = 0;
  int            burst_left = 0;
  int            cycle_count = 0;
  int            stall_style = 0;
  int            stall_left = 0;
  int            rx_tick = 0;

  eager_ring_space_allocator_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  function automatic alloc_result_t result_of(input logic [KIND_W-1:0] kind,
                                              input logic [OFF_W-1:0] offset,
                                              input logic [CNT_W-1:0] count,
                                              input logic [SEQ_W-1:0] seq,
                                              input logic last);
    alloc_result_t r;
    r.kind   = kind;
    r.offset = offset;
    r.count  = count;
    r.seq    = seq;
    r.last   = last;
    return r;
  endfunction

  // Ring size in bytes; the log2 register saturates into the legal range.
  function automatic logic [63:0] ring_span();
    logic [LG_W-1:0] lg;
    lg = ring_lg;
    if (lg < 4) lg = LG_W'(4);
    if (lg > MAX_RING_LOG2_DEF) lg = LG_W'(MAX_RING_LOG2_DEF);
    return 64'd1 << lg;
  endfunction

  // Judge one send attempt; return 1 when padding went out and the send must be judged again.
  function automatic bit claim_once(input logic [LEN_W-1:0] n, output alloc_result_t r);
    logic [63:0] span, mask, roff, eoff, pad;
    logic [64:0] fin;
    bit          padded;
    span = ring_span();
    mask = span - 64'd1;
    padded = 1'b0;
    fin = {1'b0, prod_ptr} + {44'd0, n};
    if (n == '0 || {43'd0, n} >= span) begin
      r = result_of(KIND_TOO_LARGE, '0, n, '0, 1'b1);
    end else if (fin[64] || fin[63:0] > {1'b0, lifetime_cap}) begin
      r = result_of(KIND_LIFETIME, '0, n, '0, 1'b1);
    end else if (fin[63:0] - cons_ptr > span) begin
      // also catches a consumer that has run ahead of the producer
      r = result_of(KIND_RETRY, '0, n, '0, 1'b1);
    end else begin
      roff = prod_ptr & mask;
      eoff = fin[63:0] & mask;
      if (eoff <= roff) begin
        // message would reach the ring end: pad up to it and jump to the next lap
        pad = span - roff;
        r = result_of(KIND_PAD, roff[OFF_W-1:0], pad[CNT_W-1:0], '0, 1'b0);
        prod_ptr = prod_ptr + pad;
        padded = 1'b1;
      end else begin
        r = result_of(KIND_PLACED, roff[OFF_W-1:0], n, seq_next, 1'b1);
        seq_next = seq_next + 64'd1;
        prod_ptr = fin[63:0];
      end
    end
    return padded;
  endfunction

  // Advance the predictor by one accepted request; queue its results when asked.
  function automatic void judge_request(input logic [MODE_W-1:0] mode,
                                        input logic [LEN_W-1:0] len, input bit keep);
    logic [63:0]   span, idx, skip;
    alloc_result_t first, second;
    bit            padded;
    span = ring_span();
    idx = cons_ptr & (span - 64'd1);
    skip = span - idx;
    if (mode == MODE_SEND) begin
      padded = claim_once(len, first);
      if (keep) pending.push_back(first);
      if (padded) begin
        void'(claim_once(len, second));
        if (keep) pending.push_back(second);
      end
    end else if (mode == MODE_CONSUME) begin
      if (keep) pending.push_back(result_of(KIND_CONSUMED, idx[OFF_W-1:0], len, '0, 1'b1));
      cons_ptr = cons_ptr + {43'd0, len};
    end else if (mode == MODE_CWRAP) begin
      // a consumer already on a boundary skips a whole ring
      if (keep) pending.push_back(result_of(KIND_CWRAPPED, idx[OFF_W-1:0], skip[CNT_W-1:0],
                                            '0, 1'b1));
      cons_ptr = cons_ptr + skip;
    end
  endfunction

  function automatic void plan_item(input logic [MODE_W-1:0] mode, input logic [LEN_W-1:0] len);
    plan_step_t st;
    st.is_cfg  = 1'b0;
    st.reg_sel = '0;
    st.reg_val = '0;
    st.mode    = mode;
    st.len     = len;
    st.typed   = 1'b0;
    st.want    = '0;
    plan.push_back(st);
  endfunction

  function automatic void plan_typed(input logic [MODE_W-1:0] mode, input logic [LEN_W-1:0] len,
                                     input alloc_result_t want);
    plan_step_t st;
    st.is_cfg  = 1'b0;
    st.reg_sel = '0;
    st.reg_val = '0;
    st.mode    = mode;
    st.len     = len;
    st.typed   = 1'b1;
    st.want    = want;
    plan.push_back(st);
  endfunction

  function automatic void plan_write(input logic [CFG_IDX_W-1:0] sel, input logic [LIMIT_W-1:0] val);
    plan_step_t st;
    st.is_cfg  = 1'b1;
    st.reg_sel = sel;
    st.reg_val = val;
    st.mode    = MODE_SEND;
    st.len     = '0;
    st.typed   = 1'b0;
    st.want    = '0;
    plan.push_back(st);
  endfunction

  // Enter and leave on a falling edge. Requests go out in bursts with random gaps between.
  task automatic drive_request(input logic [MODE_W-1:0] mode, input logic [LEN_W-1:0] len,
                               input bit typed, input alloc_result_t want);
    int gap;
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left = burst_left - 1;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {3'b000, len};
    s_axis_tuser  = mode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    // transfer taken at this edge: predict now, ahead of any result
    judge_request(mode, len, !typed);
    if (typed) pending.push_back(want);
    if (mode != MODE_IGNORED) requests_sent = requests_sent + 1;
    @(negedge clk);
  endtask

  // Hold the input idle until every owed result is out, then let the pipe empty.
  task automatic settle_idle();
    s_axis_tvalid = 1'b0;
    burst_left = 0;
    while (pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] val);
    settle_idle();
    cfg_we    = 1'b1;
    cfg_index = sel;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (sel == CFG_RING_LOG2) ring_lg = val[LG_W-1:0];
    else lifetime_cap = val[LIMIT_W-1:0];
  endtask

  // Random requests against the live predictor state. Tame phases keep the consumer behind
  // the producer so sends keep landing; the wild phase lets it run ahead.
  task automatic random_phase(input int count, input bit wild);
    int                made;
    int unsigned       span32;
    logic [63:0]       span, idx, roff, backlog;
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  len;
    int unsigned       avail;
    int                pick;
    made = 0;
    while (made < count) begin
      span = ring_span();
      span32 = span[31:0];
      idx = cons_ptr & (span - 64'd1);
      roff = prod_ptr & (span - 64'd1);
      backlog = prod_ptr - cons_ptr;
      avail = (backlog > 64'h1FFFFF) ? 32'h1FFFFF : backlog[31:0];
      pick = $urandom_range(0, 99);
      if (wild) begin
        mode = MODE_SEND + MODE_W'($urandom_range(0, 3));
        len = (pick < 60) ? LEN_W'($urandom_range(0, span32))
                          : LEN_W'($urandom_range(0, 21'h1FFFFF));
      end else if (pick < 4) begin
        mode = MODE_IGNORED;
        len = LEN_W'($urandom_range(0, 21'h1FFFFF));
      end else if (pick < 52) begin
        mode = MODE_SEND;
        case ($urandom_range(0, 9))
          0, 1, 2, 3: len = LEN_W'($urandom_range(1, (span32 > 4) ? span32 / 4 : 1));
          4, 5:       len = LEN_W'($urandom_range(1, span32 - 1));
          6:          len = LEN_W'(span32 - roff[31:0]);   // lands exactly on the ring end
          7:          len = $urandom_range(0, 1) ? LEN_W'(span32 - 1) : LEN_W'(span32);
          8:          len = $urandom_range(0, 1) ? '0
                                                 : LEN_W'($urandom_range(span32, 21'h1FFFFF));
          default:    len = LEN_W'($urandom_range(0, 21'h1FFFFF));
        endcase
      end else if (pick < 88 || backlog < span - idx) begin
        mode = MODE_CONSUME;
        case ($urandom_range(0, 9))
          0, 1:    len = LEN_W'(avail);
          2:       len = LEN_W'($urandom_range(0, (avail < 8) ? avail : 8));
          default: len = LEN_W'($urandom_range(0, avail));
        endcase
      end else begin
        // the length field is don't-care here; keep it random
        mode = MODE_CWRAP;
        len = LEN_W'($urandom_range(0, 21'h1FFFFF));
      end
      drive_request(mode, len, 1'b0, '0);
      if (mode != MODE_IGNORED) made = made + 1;
    end
  endtask

  // Receiver: switch at random between stall styles, one of them never stalling.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end
    stall_left = stall_left - 1;
    rx_tick = rx_tick + 1;
    case (stall_style)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (rx_tick % 4 != 3);
    endcase
  end

  // Result checker: every transfer must match the oldest owed result, field by field.
  always @(posedge clk) begin
    alloc_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind   = m_axis_tuser;
      got.offset = m_axis_tdata[19:0];
      got.count  = m_axis_tdata[40:20];
      got.seq    = m_axis_tdata[104:41];
      got.last   = m_axis_tlast;
      kind_seen[got.kind] = kind_seen[got.kind] + 1;
      if (pending.size() == 0) begin
        $error("unexpected result: kind %0d offset %0h count %0h", got.kind, got.offset,
               got.count);
        fail_count = fail_count + 1;
      end else begin
        want = pending.pop_front();
        if (got.kind !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, got.kind);
          fail_count = fail_count + 1;
        end
        if (got.offset !== want.offset) begin
          $error("ring_offset: expected %0h, got %0h", want.offset, got.offset);
          fail_count = fail_count + 1;
        end
        if (got.count !== want.count) begin
          $error("byte_count: expected %0h, got %0h", want.count, got.count);
          fail_count = fail_count + 1;
        end
        if (got.seq !== want.seq) begin
          $error("sequence_number: expected %0h, got %0h", want.seq, got.seq);
          fail_count = fail_count + 1;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, got.last);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[eager_ring_space_allocator_top] ERROR");
      $finish;
    end
  end

  initial begin
    logic [LG_W-1:0]    lg;
    logic [63:0]        junk;
    logic [LIMIT_W-1:0] cap;
    int                 phase;

    for (int k = 0; k < 8; k++) kind_seen[k] = 0;

    // Hold reset from the start, drop it on a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table, default 4 KiB ring. Rows with a result typed in are the obvious ones.
    plan_typed(MODE_SEND, 21'd0, result_of(KIND_TOO_LARGE, '0, 21'd0, '0, 1'b1));
    plan_typed(MODE_SEND, 21'd4096, result_of(KIND_TOO_LARGE, '0, 21'd4096, '0, 1'b1));
    plan_typed(MODE_SEND, 21'h1FFFFF, result_of(KIND_TOO_LARGE, '0, 21'h1FFFFF, '0, 1'b1));
    plan_typed(MODE_SEND, 21'd4095, result_of(KIND_PLACED, '0, 21'd4095, '0, 1'b1));
    plan_item(MODE_SEND, 21'd1);          // pads one byte, then retries: ring is full
    plan_item(MODE_CWRAP, 21'd0);         // consumer on a boundary skips a whole ring
    plan_item(MODE_SEND, 21'd100);
    plan_item(MODE_SEND, 21'd4000);       // four bytes short of room: retry
    plan_item(MODE_CONSUME, 21'd100);
    plan_item(MODE_SEND, 21'd3996);       // ends exactly on the ring end: pad, then retry
    plan_item(MODE_CWRAP, 21'h1FFFFF);
    plan_item(MODE_SEND, 21'd4000);
    plan_item(MODE_CONSUME, 21'd4000);
    plan_item(MODE_SEND, 21'd200);        // crosses the end: pad, then place at zero
    plan_item(MODE_IGNORED, 21'h1FFFFF);
    plan_item(MODE_CONSUME, 21'd0);
    plan_write(CFG_LIFETIME, '0);
    plan_typed(MODE_SEND, 21'd1, result_of(KIND_LIFETIME, '0, 21'd1, '0, 1'b1));
    plan_typed(MODE_SEND, 21'h100000, result_of(KIND_TOO_LARGE, '0, 21'h100000, '0, 1'b1));
    plan_write(CFG_LIFETIME, LIMIT_RESET);
    plan_write(CFG_RING_LOG2, 63'd0);     // saturates to the smallest ring
    plan_typed(MODE_SEND, 21'd16, result_of(KIND_TOO_LARGE, '0, 21'd16, '0, 1'b1));
    plan_item(MODE_CONSUME, 21'd296);
    plan_item(MODE_SEND, 21'd15);
    plan_write(CFG_RING_LOG2, 63'd31);    // saturates to the largest ring
    plan_typed(MODE_SEND, 21'h100000, result_of(KIND_TOO_LARGE, '0, 21'h100000, '0, 1'b1));
    plan_item(MODE_SEND, 21'hFFFFF);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_register(plan[i].reg_sel, plan[i].reg_val);
      else drive_request(plan[i].mode, plan[i].len, plan[i].typed, plan[i].want);
    end

    // Random phases, each under its own ring size and lifetime limit.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       lg = 5'd12;
        1:       lg = 5'd4;
        2:       lg = 5'd20;
        3:       lg = 5'd0;
        4:       lg = 5'd31;
        5:       lg = 5'd7;
        6:       lg = LG_W'($urandom_range(4, 20));
        7:       lg = LG_W'($urandom_range(0, 31));
        default: lg = 5'd9;
      endcase
      junk = {$urandom, $urandom};
      // odd phases also set the unused upper data bits of the log2 write
      write_register(CFG_RING_LOG2, phase % 2 ? {junk[62:5], lg} : {58'd0, lg});
      case (phase % 3)
        0:       cap = LIMIT_RESET;
        1:       cap = prod_ptr[LIMIT_W-1:0]
                       + LIMIT_W'($urandom_range(0, 32'(3 * ring_span())));
        default: cap = junk[63:1];
      endcase
      write_register(CFG_LIFETIME, cap);
      random_phase(ITEMS_PER_PHASE, phase == PHASES - 1);
    end

    // Drain and let the block go quiet before the verdict.
    s_axis_tvalid = 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d requests under %0d register settings: %0d placed, %0d padding,",
             requests_sent, PHASES + 1, kind_seen[KIND_PLACED], kind_seen[KIND_PAD]);
    $display("  %0d too large, %0d past lifetime, %0d retry, %0d consumed, %0d consumer wraps",
             kind_seen[KIND_TOO_LARGE], kind_seen[KIND_LIFETIME], kind_seen[KIND_RETRY],
             kind_seen[KIND_CONSUMED], kind_seen[KIND_CWRAPPED]);
    if (fail_count == 0) begin
      $display("[eager_ring_space_allocator_top] OK");
    end else begin
      $display("[eager_ring_space_allocator_top] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
hw/rtl/esa_pkg.sv
hw/rtl/esa_core.sv
hw/rtl/esa_outq.sv
hw/rtl/eager_ring_space_allocator_top.sv
hw/rtl/esa_checker.sv
bench/eager_ring_space_allocator_top_test.sv
